/* rtl/nrtd_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nrtd_pkg: shared types and constants for the RMC time/date parser
// Transaction payloads, the snapshot handed from the field tracker to the
// result stage, and the character codes of the sentence grammar.
// ----------------------------------------------------------------------------
package nrtd_pkg;

  // Field counter saturation point (commas beyond this are ignored).
  localparam logic [3:0] MAX_FIELDS   = 4'd11;
  localparam logic [3:0] BEFORE_FIRST = 4'd15;
  localparam logic [3:0] TIME_FIELD   = 4'd0;
  localparam logic [3:0] STATUS_FIELD = 4'd1;
  localparam logic [3:0] DATE_FIELD   = 4'd8;

  localparam logic [2:0] HDR_LEN     = 3'd5;
  localparam logic [2:0] DIGITS_KEPT = 3'd6;
  localparam logic [2:0] CHAR_LIMIT  = 3'd7;

  localparam logic [7:0] CHAR_COMMA = 8'h2C;
  localparam logic [7:0] CHAR_A     = 8'h41;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;

  typedef struct packed {
    logic [7:0] char_in;
    logic       last_char;
  } nrtd_in_t;

  typedef struct packed {
    logic       is_rmc;
    logic [7:0] hours;
    logic [7:0] minutes;
    logic [7:0] seconds;
    logic [7:0] day_of_month;
    logic [7:0] month_num;
    logic [7:0] year_two_digit;
    logic       fix_active;
  } nrtd_out_t;

  // Six captured digits, digit k in element k.
  typedef logic [5:0][3:0] nrtd_nibbles_t;

  // Sentence state after the current character, as seen by the result stage.
  typedef struct packed {
    logic          hdr_match;
    nrtd_nibbles_t time_nib;
    nrtd_nibbles_t date_nib;
    logic          fix;
  } nrtd_snap_t;

  // Expected header text, one character per position.
  function automatic logic [7:0] hdr_char(input logic [2:0] idx);
    logic [7:0] ch;
    begin
      unique case (idx)
        3'd0:    ch = 8'h47; // G
        3'd1:    ch = 8'h50; // P
        3'd2:    ch = 8'h52; // R
        3'd3:    ch = 8'h4D; // M
        3'd4:    ch = 8'h43; // C
        default: ch = 8'h00;
      endcase
      return ch;
    end
  endfunction

endpackage

/* rtl/nrtd_field_track.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nrtd_field_track: per-character sentence state
// Checks the header, counts fields and captures the time, date and status
// characters. Returns to the idle state after the last character.
// ----------------------------------------------------------------------------
module nrtd_field_track
  import nrtd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,
  input  nrtd_in_t   item_i,
  output nrtd_snap_t snap_o
);

  logic [2:0]    hdr_cnt_q, hdr_cnt_d;
  logic          hdr_ok_q, hdr_ok_d;
  logic [3:0]    field_q, field_d;
  logic [2:0]    char_pos_q, char_pos_d;
  nrtd_nibbles_t time_q, time_d;
  nrtd_nibbles_t date_q, date_d;
  logic          fix_q, fix_d;
  logic [7:0]    diff;
  logic [3:0]    digit;

  assign diff  = item_i.char_in - CHAR_ZERO;
  assign digit = diff[3:0];

  always_comb begin
    hdr_cnt_d  = hdr_cnt_q;
    hdr_ok_d   = hdr_ok_q;
    field_d    = field_q;
    char_pos_d = char_pos_q;
    time_d     = time_q;
    date_d     = date_q;
    fix_d      = fix_q;

    if (hdr_cnt_q < HDR_LEN) begin
      if (item_i.char_in != hdr_char(hdr_cnt_q)) begin
        hdr_ok_d = 1'b0;
      end
      hdr_cnt_d = hdr_cnt_q + 3'd1;
    end

    if (item_i.char_in == CHAR_COMMA) begin
      if (field_q == BEFORE_FIRST) begin
        field_d = TIME_FIELD;
      end else if (field_q < MAX_FIELDS) begin
        field_d = field_q + 4'd1;
      end
      char_pos_d = 3'd0;
    end else begin
      if (char_pos_q < DIGITS_KEPT) begin
        if (field_q == TIME_FIELD) begin
          time_d[char_pos_q] = digit;
        end else if (field_q == DATE_FIELD) begin
          date_d[char_pos_q] = digit;
        end
      end
      if (field_q == STATUS_FIELD && char_pos_q == 3'd0) begin
        fix_d = (item_i.char_in == CHAR_A);
      end
      if (char_pos_q < CHAR_LIMIT) begin
        char_pos_d = char_pos_q + 3'd1;
      end
    end
  end

  assign snap_o.hdr_match = (hdr_cnt_d >= HDR_LEN) && hdr_ok_d;
  assign snap_o.time_nib  = time_d;
  assign snap_o.date_nib  = date_d;
  assign snap_o.fix       = fix_d;

  // Drop back to the idle state once the sentence is complete.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_cnt_q  <= 3'd0;
      hdr_ok_q   <= 1'b1;
      field_q    <= BEFORE_FIRST;
      char_pos_q <= 3'd0;
      time_q     <= '0;
      date_q     <= '0;
      fix_q      <= 1'b0;
    end else if (step_i) begin
      if (item_i.last_char) begin
        hdr_cnt_q  <= 3'd0;
        hdr_ok_q   <= 1'b1;
        field_q    <= BEFORE_FIRST;
        char_pos_q <= 3'd0;
        time_q     <= '0;
        date_q     <= '0;
        fix_q      <= 1'b0;
      end else begin
        hdr_cnt_q  <= hdr_cnt_d;
        hdr_ok_q   <= hdr_ok_d;
        field_q    <= field_d;
        char_pos_q <= char_pos_d;
        time_q     <= time_d;
        date_q     <= date_d;
        fix_q      <= fix_d;
      end
    end
  end

endmodule

/* rtl/nrtd_result.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nrtd_result: result register
// Turns captured digit pairs into values and holds the result transaction
// until the receiver takes it.
// ----------------------------------------------------------------------------
module nrtd_result
  import nrtd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       load_i,
  input  nrtd_snap_t snap_i,
  input  logic       out_stall_i,
  output logic       out_valid_o,
  output nrtd_out_t  out_data_o
);

  // 10 * hi + lo, at most 165.
  function automatic logic [7:0] pair_value(input logic [3:0] hi, input logic [3:0] lo);
    logic [7:0] x8;
    logic [7:0] x2;
    begin
      x8 = {1'b0, hi, 3'b000};
      x2 = {3'b000, hi, 1'b0};
      return x8 + x2 + {4'b0000, lo};
    end
  endfunction

  logic      valid_q;
  nrtd_out_t data_q, data_d;

  always_comb begin
    data_d = '0;
    if (snap_i.hdr_match) begin
      data_d.is_rmc         = 1'b1;
      data_d.hours          = pair_value(snap_i.time_nib[0], snap_i.time_nib[1]);
      data_d.minutes        = pair_value(snap_i.time_nib[2], snap_i.time_nib[3]);
      data_d.seconds        = pair_value(snap_i.time_nib[4], snap_i.time_nib[5]);
      data_d.day_of_month   = pair_value(snap_i.date_nib[0], snap_i.date_nib[1]);
      data_d.month_num      = pair_value(snap_i.date_nib[2], snap_i.date_nib[3]);
      data_d.year_two_digit = pair_value(snap_i.date_nib[4], snap_i.date_nib[5]);
      data_d.fix_active     = snap_i.fix;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= data_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

/* rtl/nmea_rmc_time_date_parser_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nmea_rmc_time_date_parser_core: RMC sentence time/date parser
// Takes one sentence character per transaction and returns one result
// transaction (header match, time, date, fix) on the last character.
// ----------------------------------------------------------------------------
//
//   channel | direction | payload     | transaction
//   --------+-----------+-------------+-------------------------------------
//   in      | sink      | nrtd_in_t   | one character, last one flagged
//   out     | source    | nrtd_out_t  | one result per sentence
//
// Cycles: one character per cycle sustained when the input is not stalled;
// a last character is held in the input register, and the result register
// loads from it, through the parse logic, when that character advances;
// the result can then be taken from the result register.
// Reset: rst_ni clears the sentence state; no clearing pass is needed.
// Stalls: only a last character waits on a full, stalled result register;
// other characters keep flowing while a result waits to be taken.
// ----------------------------------------------------------------------------
module nmea_rmc_time_date_parser_core
  import nrtd_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  nrtd_in_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output nrtd_out_t out_data_o
);

  logic       in_valid_q;
  nrtd_in_t   in_q;
  logic       accept;
  logic       advance;
  logic       load;
  nrtd_snap_t snap;

  // Advance the held character unless it would produce a result that
  // cannot be written because the result register is full and stalled.
  assign advance = in_valid_q &&
                   (!in_q.last_char || !out_valid_o || !out_stall_i);
  assign load    = advance && in_q.last_char;

  // Stall the input only while the held character cannot advance.
  assign in_stall_o = in_valid_q && !advance;
  assign accept     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (accept) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  // Hold the payload; load only on an accepted transaction.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_q <= in_data_i;
    end
  end

  nrtd_field_track u_field_track (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (advance),
    .item_i (in_q),
    .snap_o (snap)
  );

  nrtd_result u_result (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (load),
    .snap_i      (snap),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

`ifndef SYNTH
  // Input stalls only behind a last character blocked by a stalled result.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (in_valid_q && in_q.last_char && out_valid_o && out_stall_i))
    else $error("input stalled without a blocked result");

  // A new result appears only after a last character was parsed.
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(load))
    else $error("result raised without a last character");

  // A sentence that is not RMC reports all zeros.
  a_non_rmc_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_data_o.is_rmc) |->
      (out_data_o.hours == 8'd0 && out_data_o.minutes == 8'd0 &&
       out_data_o.seconds == 8'd0 && out_data_o.day_of_month == 8'd0 &&
       out_data_o.month_num == 8'd0 && out_data_o.year_two_digit == 8'd0 &&
       !out_data_o.fix_active))
    else $error("non-RMC result carries data");
`endif

endmodule

/* tb/nmea_rmc_time_date_parser_core_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nmea_rmc_time_date_parser_core_tb: self-checking bench for the RMC parser
// Streams sentence characters into the parser. Most sentences are
// well-formed RMC lines with random time, status and date content. The rest
// are broken headers, truncated headers, runs of extra commas and raw byte
// noise. A local parse model predicts every result transaction, and each one
// is checked field by field in arrival order. Both sides idle and stall at
// random, and one long receiver hold-off backs the parser up into its input.
// ----------------------------------------------------------------------------
module nmea_rmc_time_date_parser_core_tb;
  import nrtd_pkg::*;

  typedef logic [7:0] byte_q_t[$];

  // Characters of the sentence header, first one in the top byte.
  localparam logic [39:0] RMC_TEXT = "GPRMC";

  localparam int RANDOM_CHARS = 1850;
  localparam int HOLD_AT      = 300;   // accepted characters before the hold-off
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 10;
  localparam int CYCLE_LIMIT  = 400000;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  nrtd_in_t  in_data   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  nrtd_out_t out_data;

  // Characters waiting to be offered, and results waiting to arrive.
  nrtd_in_t  char_q[$];
  nrtd_out_t rmc_expect_q[$];

  // Parse state of the local model.
  logic [2:0]    hdr_cnt;
  logic          hdr_ok;
  logic [3:0]    fld_num;
  logic [2:0]    fld_pos;
  nrtd_nibbles_t time_nib;
  nrtd_nibbles_t date_nib;
  logic          fix_bit;

  int err_cnt      = 0;
  int result_cnt   = 0;
  int accepted_cnt = 0;
  int hold_left    = 0;
  bit hold_done    = 1'b0;
  int cycle_cnt    = 0;
  int tx_gap       = 0;
  int tx_calm      = 0;
  int rx_stall     = 0;
  int rx_calm      = 0;

  nmea_rmc_time_date_parser_core u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  // --------------------------------------------------------------------------
  // Parse model
  // --------------------------------------------------------------------------

  // Return to the start-of-sentence state.
  task automatic clear_parse();
    hdr_cnt  = '0;
    hdr_ok   = 1'b1;
    fld_num  = BEFORE_FIRST;
    fld_pos  = '0;
    time_nib = '0;
    date_nib = '0;
    fix_bit  = 1'b0;
  endtask

  // Two-digit value: digit pos is the tens, digit pos+1 the units.
  function automatic logic [7:0] pair_val(input nrtd_nibbles_t nib, input int pos);
    return 8'(10 * nib[pos] + nib[pos + 1]);
  endfunction

  // Advance the model by one accepted character; queue a result on the last.
  task automatic advance_parse(input nrtd_in_t it);
    logic [7:0] ch;
    logic [3:0] dig;
    logic       ok;
    nrtd_out_t  res;
    ch = it.char_in;
    // Compare only the first five characters against the header text.
    if (hdr_cnt < HDR_LEN) begin
      if (ch != RMC_TEXT[39 - 8 * hdr_cnt -: 8]) hdr_ok = 1'b0;
      hdr_cnt++;
    end
    if (ch == CHAR_COMMA) begin
      // Leave the header on the first comma, then count up and saturate.
      if (fld_num == BEFORE_FIRST) fld_num = TIME_FIELD;
      else if (fld_num < MAX_FIELDS) fld_num++;
      fld_pos = '0;
    end else begin
      // Digits are taken unchecked, so any byte lands as a nibble.
      dig = 4'(ch - CHAR_ZERO);
      if (fld_pos < DIGITS_KEPT) begin
        if (fld_num == TIME_FIELD) time_nib[fld_pos] = dig;
        else if (fld_num == DATE_FIELD) date_nib[fld_pos] = dig;
      end
      if (fld_num == STATUS_FIELD && fld_pos == 0) fix_bit = (ch == CHAR_A);
      if (fld_pos < CHAR_LIMIT) fld_pos++;
    end
    if (it.last_char) begin
      ok  = (hdr_cnt >= HDR_LEN) && hdr_ok;
      res = '0;
      // A sentence that is not RMC reports all zeros.
      if (ok) begin
        res.is_rmc         = 1'b1;
        res.hours          = pair_val(time_nib, 0);
        res.minutes        = pair_val(time_nib, 2);
        res.seconds        = pair_val(time_nib, 4);
        res.day_of_month   = pair_val(date_nib, 0);
        res.month_num      = pair_val(date_nib, 2);
        res.year_two_digit = pair_val(date_nib, 4);
        res.fix_active     = fix_bit;
      end
      rmc_expect_q.push_back(res);
      clear_parse();
    end
  endtask

  // --------------------------------------------------------------------------
  // Checking
  // --------------------------------------------------------------------------

  task automatic report_mismatch(input string what, input int got, input int want);
    err_cnt++;
    $display("mismatch in result %0d: %s got %0d expected %0d",
             result_cnt, what, got, want);
  endtask

  task automatic check_result(input nrtd_out_t got);
    nrtd_out_t want;
    if (rmc_expect_q.size() == 0) begin
      report_mismatch("result with nothing pending", 1, 0);
    end else begin
      want = rmc_expect_q.pop_front();
      if (got.is_rmc !== want.is_rmc)
        report_mismatch("is_rmc", got.is_rmc, want.is_rmc);
      if (got.hours !== want.hours)
        report_mismatch("hours", got.hours, want.hours);
      if (got.minutes !== want.minutes)
        report_mismatch("minutes", got.minutes, want.minutes);
      if (got.seconds !== want.seconds)
        report_mismatch("seconds", got.seconds, want.seconds);
      if (got.day_of_month !== want.day_of_month)
        report_mismatch("day_of_month", got.day_of_month, want.day_of_month);
      if (got.month_num !== want.month_num)
        report_mismatch("month_num", got.month_num, want.month_num);
      if (got.year_two_digit !== want.year_two_digit)
        report_mismatch("year_two_digit", got.year_two_digit, want.year_two_digit);
      if (got.fix_active !== want.fix_active)
        report_mismatch("fix_active", got.fix_active, want.fix_active);
    end
    result_cnt++;
  endtask

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------

  // Gap length: mostly none or short, now and then long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic void add_str(ref byte_q_t s, input string t);
    for (int i = 0; i < t.len(); i++) s.push_back(t[i]);
  endfunction

  // Queue a sentence, flagging its final character.
  task automatic queue_sentence(input byte_q_t s);
    nrtd_in_t it;
    for (int i = 0; i < s.size(); i++) begin
      it.char_in   = s[i];
      it.last_char = (i == s.size() - 1);
      char_q.push_back(it);
    end
  endtask

  // Digits for the time or date field: usually six, sometimes short or long,
  // with the odd stray byte mixed in.
  task automatic add_digits(ref byte_q_t s, input bit frac);
    int r;
    int len;
    r = $urandom_range(0, 99);
    if (r < 70) len = 6;
    else if (r < 80) len = 0;
    else len = $urandom_range(1, 10);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 19) == 0) s.push_back(8'($urandom));
      else s.push_back(8'($urandom_range(8'h30, 8'h39)));
    end
    if (frac && len != 0 && $urandom_range(0, 1)) add_str(s, ".00");
  endtask

  task automatic gen_sentence();
    byte_q_t s;
    int      kind;
    int      nf;
    int      len;
    int      r;
    kind = $urandom_range(0, 99);
    if (kind < 8) begin
      // Raw byte noise.
      len = $urandom_range(1, 20);
      repeat (len) s.push_back(8'($urandom));
    end else if (kind < 12) begin
      // Header cut short.
      len = $urandom_range(1, 4);
      for (int i = 0; i < len; i++) s.push_back(RMC_TEXT[39 - 8 * i -: 8]);
    end else begin
      add_str(s, "GPRMC");
      if (kind < 20) s[$urandom_range(0, 4)] = 8'($urandom);
      // Most sentences reach the date field; some stop early or run long.
      nf = (kind < 32) ? $urandom_range(0, 15) : $urandom_range(9, 12);
      for (int f = 0; f < nf; f++) begin
        s.push_back(CHAR_COMMA);
        if (f == TIME_FIELD) begin
          add_digits(s, 1'b1);
        end else if (f == DATE_FIELD) begin
          add_digits(s, 1'b0);
        end else if (f == STATUS_FIELD) begin
          r = $urandom_range(0, 9);
          if (r < 5) s.push_back(CHAR_A);
          else if (r < 8) s.push_back("V");
          else if (r < 9) s.push_back(8'($urandom));
          if ($urandom_range(0, 9) == 0) add_str(s, "AV");
        end else begin
          len = $urandom_range(0, 5);
          repeat (len) s.push_back(8'($urandom_range(8'h2D, 8'h5A)));
        end
      end
      if ($urandom_range(0, 3) == 0) begin
        s.push_back("*");
        s.push_back(8'($urandom_range(8'h30, 8'h46)));
        s.push_back(8'($urandom_range(8'h30, 8'h46)));
      end
      if (s.size() == 0) s.push_back(CHAR_COMMA);
    end
    queue_sentence(s);
  endtask

  // --------------------------------------------------------------------------
  // Sender: offer queued characters, hold each one until it is taken
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data  <= '0;
      clear_parse();
    end else begin
      if (in_valid && !in_stall) begin
        advance_parse(in_data);
        accepted_cnt <= accepted_cnt + 1;
      end
      // Change the payload only when the slot is empty or was just taken.
      if (!in_valid || !in_stall) begin
        if (tx_gap > 0) begin
          tx_gap--;
          in_valid <= 1'b0;
        end else if (char_q.size() > 0) begin
          in_valid <= 1'b1;
          in_data  <= char_q.pop_front();
          if (tx_calm > 0) begin
            tx_calm--;
          end else begin
            tx_gap = pick_gap();
            if ($urandom_range(0, 249) == 0) tx_calm = $urandom_range(50, 150);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: check every result taken, stall at random
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) check_result(out_data);
      if (hold_left != 0) begin
        out_stall <= 1'b1;
      end else if (rx_stall > 0) begin
        rx_stall--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
        if (rx_calm > 0) rx_calm--;
        else if ($urandom_range(0, 2) == 0) rx_stall = pick_gap();
        else if ($urandom_range(0, 199) == 0) rx_calm = $urandom_range(50, 200);
      end
    end
  end

  // Hold the receiver off once for a long stretch so results pile up and the
  // next last character backs up into the input.
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
    end else if (!hold_done && accepted_cnt >= HOLD_AT) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Stop a hung run.
  initial begin
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("[nmea_rmc_time_date_parser_core] ERROR");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    byte_q_t s;
    nrtd_in_t it;

    // Directed: a full sentence at the top of every range, a header that
    // fails on its last character, and lone extreme bytes as whole sentences.
    add_str(s, "GPRMC,235959,A,,,,,,,311299");
    queue_sentence(s);
    s = {};
    add_str(s, "GPRMD");
    queue_sentence(s);
    it.char_in   = 8'hFF;
    it.last_char = 1'b1;
    char_q.push_back(it);
    it.char_in   = 8'h00;
    char_q.push_back(it);

    // Random sentences until the character budget is spent.
    while (char_q.size() < RANDOM_CHARS) gen_sentence();

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Drain: everything offered, taken, and answered.
    while (char_q.size() != 0 || in_valid || rmc_expect_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (err_cnt == 0) begin
      $display("[nmea_rmc_time_date_parser_core] OK");
    end else begin
      $display("[nmea_rmc_time_date_parser_core] ERROR");
    end
    $finish;
  end

endmodule

/* nmea_rmc_time_date_parser_core.f */
rtl/nrtd_pkg.sv
rtl/nrtd_field_track.sv
rtl/nrtd_result.sv
rtl/nmea_rmc_time_date_parser_core.sv
tb/nmea_rmc_time_date_parser_core_tb.sv
